// ===== rtl/i2cs_pkg.sv =====
// Shared constants and command codes of the I2C master bit sequencer.
package i2cs_pkg;

  localparam int CmdW  = 4;
  localparam int DataW = 8;
  localparam int TickW = 8;

  localparam logic [DataW-1:0] PhaseTicksRst = 8'd15;

  // Command codes, also used as the running-operation code
  localparam logic [CmdW-1:0] OpIdle   = 4'd0;
  localparam logic [CmdW-1:0] OpStart  = 4'd1;
  localparam logic [CmdW-1:0] OpStop   = 4'd2;
  localparam logic [CmdW-1:0] OpWrite  = 4'd3;
  localparam logic [CmdW-1:0] OpRead   = 4'd4;
  localparam logic [CmdW-1:0] OpAck    = 4'd5;
  localparam logic [CmdW-1:0] OpNack   = 4'd6;
  localparam logic [CmdW-1:0] OpCheck  = 4'd7;
  localparam logic [CmdW-1:0] OpBusRst = 4'd8;

  // Register indexes on the configuration port
  localparam logic RegPhaseTicks = 1'b0;

endpackage

// ===== rtl/i2cs_if.sv =====
// Tick and pin-result channel interfaces of the I2C master bit sequencer.
interface i2cs_in_if;
  import i2cs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [DataW-1:0] wr_data;
  logic             sda_in;

  modport source (output valid, output cmd, output wr_data, output sda_in, input ready);
  modport sink   (input valid, input cmd, input wr_data, input sda_in, output ready);
endinterface

interface i2cs_out_if;
  import i2cs_pkg::*;

  logic             valid;
  logic             ready;
  logic             scl;
  logic             sda_release;
  logic             sda_input_mode;
  logic             write_control;
  logic             busy_res;
  logic [DataW-1:0] rd_data;
  logic             rd_valid;
  logic             ack_status;
  logic             ack_valid;
  logic             done_res;

  modport source (
    output valid, output scl, output sda_release, output sda_input_mode,
    output write_control, output busy_res, output rd_data, output rd_valid,
    output ack_status, output ack_valid, output done_res, input ready
  );
  modport sink (
    input valid, input scl, input sda_release, input sda_input_mode,
    input write_control, input busy_res, input rd_data, input rd_valid,
    input ack_status, input ack_valid, input done_res, output ready
  );
endinterface

// ===== rtl/i2c_master_bit_sequencer.sv =====
// Top level of the I2C master bit sequencer: phase sequencer, result register, APB register.
// Each input word is one timebase tick carrying an optional command and the sampled SDA
// level; every tick gives exactly one result word with the pin levels after that tick.
// A tick is accepted in every clock cycle unless a held result waits unread; its result
// appears in the single output register on the following cycle, and a new tick is taken
// while the held result is being read. Commands arriving while a sequence runs are
// ignored, as are codes 9 to 15. Each bus phase lasts phase_ticks ticks
// (APB byte address 0, reset 15, zero acts as one). A bus reset gives RESET_PULSES SCL
// pulses after one setup phase and leaves write-control low.
module i2c_master_bit_sequencer #(
  parameter int RESET_PULSES = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cs_in_if.sink     in_i,
  i2cs_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cs_pkg::*;

  localparam int BusRstPhases = 1 + 2 * RESET_PULSES;
  localparam int PhCnt        = (BusRstPhases > 16) ? BusRstPhases : 16;
  localparam int PhW          = $clog2(PhCnt);

  logic [TickW-1:0] pt_q;
  logic [CmdW-1:0]  op_q, op_d;
  logic [PhW-1:0]   ph_q, ph_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [DataW-1:0] shift_q, shift_d;
  logic             scl_q, scl_d, sda_q, sda_d, dir_q, dir_d, wc_q, wc_d, ack_q, ack_d;

  logic             accept;
  logic             enter;
  logic             done, rd_vld, ack_vld;
  logic             last_phase;
  logic [TickW-1:0] limit;
  logic [TickW-1:0] tick_inc;
  logic             cfg_wr;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegPhaseTicks);
  assign prdata = (paddr[2] == RegPhaseTicks) ? {24'b0, pt_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= PhaseTicksRst;
    end else if (cfg_wr) begin
      pt_q <= pwdata[TickW-1:0];
    end
  end

  // Output register frees up as soon as its word is taken
  assign in_i.ready = !out_o.valid || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign limit    = (pt_q == '0) ? TickW'(1) : pt_q;
  assign tick_inc = tick_q + TickW'(1);

  always_comb begin
    unique case (op_q)
      OpStart:                         last_phase = (ph_q == PhW'(2));
      OpStop, OpAck, OpNack, OpCheck:  last_phase = (ph_q == PhW'(1));
      OpWrite, OpRead:                 last_phase = (ph_q == PhW'(15));
      OpBusRst:                        last_phase = (ph_q == PhW'(BusRstPhases - 1));
      default:                         last_phase = 1'b1;
    endcase
  end

  always_comb begin
    op_d    = op_q;
    ph_d    = ph_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    dir_d   = dir_q;
    wc_d    = wc_q;
    ack_d   = ack_q;
    enter   = 1'b0;
    done    = 1'b0;
    rd_vld  = 1'b0;
    ack_vld = 1'b0;

    if (op_q == OpIdle) begin
      if (in_i.cmd >= OpStart && in_i.cmd <= OpBusRst) begin
        op_d   = in_i.cmd;
        ph_d   = '0;
        tick_d = '0;
        if (in_i.cmd == OpWrite) begin
          shift_d = in_i.wr_data;
        end
        enter = 1'b1;
      end
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = '0;
        // sample SDA at the end of an SCL-high phase, before the pins move
        if (op_q == OpCheck && ph_q == '0) begin
          ack_d = in_i.sda_in;
        end
        if (op_q == OpRead && !ph_q[0]) begin
          shift_d = {shift_q[DataW-2:0], in_i.sda_in};
        end
        if (!last_phase) begin
          ph_d  = ph_q + PhW'(1);
          enter = 1'b1;
        end else begin
          done = 1'b1;
          if (op_q == OpWrite) begin
            sda_d = 1'b1;
          end
          if (op_q == OpRead) begin
            dir_d  = 1'b0;
            rd_vld = 1'b1;
          end
          if (op_q == OpCheck) begin
            dir_d   = 1'b0;
            ack_vld = 1'b1;
          end
          op_d = OpIdle;
          ph_d = '0;
        end
      end
    end

    // Apply the pin levels of the phase being entered
    if (enter) begin
      unique case (op_d)
        OpStart: begin
          if (ph_d == '0) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else if (ph_d == PhW'(1)) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        OpStop: begin
          if (ph_d == '0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        OpAck: begin
          scl_d = (ph_d == '0);
          sda_d = (ph_d != '0);
        end
        OpNack: begin
          scl_d = (ph_d == '0);
          sda_d = (ph_d == '0);
        end
        OpCheck: begin
          if (ph_d == '0) begin
            sda_d = 1'b1;
            dir_d = 1'b1;
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        OpWrite: begin
          // MSB first: bit index is 7 minus the bit count
          if (!ph_d[0]) begin
            sda_d = shift_d[~ph_d[3:1]];
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        OpRead: begin
          if (ph_d == '0) begin
            sda_d = 1'b1;
            dir_d = 1'b1;
          end
          scl_d = !ph_d[0];
        end
        OpBusRst: begin
          if (ph_d == '0) begin
            wc_d  = 1'b0;
            sda_d = 1'b1;
            scl_d = 1'b0;
          end else begin
            scl_d = ph_d[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OpIdle;
      ph_q    <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      dir_q   <= 1'b0;
      wc_q    <= 1'b1;
      ack_q   <= 1'b0;
    end else if (accept) begin
      op_q    <= op_d;
      ph_q    <= ph_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      dir_q   <= dir_d;
      wc_q    <= wc_d;
      ack_q   <= ack_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (accept) begin
      out_o.valid <= 1'b1;
    end else if (out_o.ready) begin
      out_o.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.scl            <= scl_d;
      out_o.sda_release    <= sda_d;
      out_o.sda_input_mode <= dir_d;
      out_o.write_control  <= wc_d;
      out_o.busy_res       <= (op_d != OpIdle);
      out_o.rd_data        <= rd_vld ? shift_d : '0;
      out_o.rd_valid       <= rd_vld;
      out_o.ack_status     <= ack_d;
      out_o.ack_valid      <= ack_vld;
      out_o.done_res       <= done;
    end
  end

  // SDA is an input only during a read or an ACK check
  a_dir_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q |-> (op_q == OpRead || op_q == OpCheck))
    else $error("SDA input mode outside read or ack check");

  // Idle leaves the phase and tick counters cleared
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OpIdle) |-> (ph_q == '0 && tick_q == '0))
    else $error("phase or tick counter left over in idle");

  // Write-control drops only when a bus reset starts
  a_wc_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(wc_q) |-> (op_q == OpBusRst))
    else $error("write-control dropped outside bus reset");

  // A completed read or ack check always ends its sequence
  a_flag_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.rd_valid || out_o.ack_valid)) |->
      (out_o.done_res && !out_o.busy_res))
    else $error("read or ack result without sequence completion");

endmodule
